>>> sv/buddy_block_allocator_unit_assert.svh
// assertion macros for the buddy allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// clocked check, held off during reset
`define BBA_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a stalled item keeps its valid and its payload
`define BBA_HOLD(name, vld, stl, sig, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && stl) |=> (vld && $stable(sig))) else $error(msg);

`endif

>>> sv/bba_pkg.sv
package bba_pkg;

  localparam int ORDERS  = 13;
  localparam int TOP     = ORDERS - 1;
  localparam int ORD_W   = $clog2(ORDERS);
  localparam int POS_W   = TOP;
  localparam int WBIT_W  = 5;
  localparam int WORD_W  = 1 << WBIT_W;
  localparam int WPTR_W  = (POS_W > WBIT_W) ? POS_W - WBIT_W : 1;
  localparam int CNT_W   = ORDERS;
  localparam int REQ_W   = 16;
  localparam int GRANT_W = 12;
  localparam int FREED_W = 13;
  localparam int KREQ_W  = 5;

  // words taken by one order's free bits
  function automatic int words_of(input int o);
    int n;
    n = (1 << (TOP - o)) >> WBIT_W;
    return (n == 0) ? 1 : n;
  endfunction

  function automatic int total_words();
    int acc;
    acc = 0;
    for (int j = 0; j < ORDERS; j++) acc += words_of(j);
    return acc;
  endfunction

  localparam int WORDS = total_words();
  localparam int AW    = $clog2(WORDS);

  // first word of an order's region
  function automatic logic [AW-1:0] obase(input logic [ORD_W-1:0] o);
    logic [AW-1:0] acc;
    acc = '0;
    for (int j = 0; j < ORDERS; j++) begin
      if (j < int'(o)) acc = acc + AW'(words_of(j));
    end
    return acc;
  endfunction

  // smallest k with 2^k >= n, n nonzero
  function automatic logic [KREQ_W-1:0] ceil_log2(input logic [REQ_W-1:0] n);
    logic [REQ_W-1:0] v;
    logic [KREQ_W-1:0] k;
    v = n - REQ_W'(1);
    k = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (v[i]) k = KREQ_W'(i + 1);
    end
    return k;
  endfunction

  // lowest set bit of a word
  function automatic logic [WBIT_W-1:0] low_bit(input logic [WORD_W-1:0] w);
    logic [WBIT_W-1:0] b;
    b = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) b = WBIT_W'(i);
    end
    return b;
  endfunction

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_SIZE   = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_A_CNT,
    S_A_RD,
    S_A_CHK,
    S_S_RD,
    S_S_WR,
    S_F_RD,
    S_F_WR,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [0:0]       action;
    logic [REQ_W-1:0] request_blocks;
    logic [REQ_W-1:0] block_index;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [GRANT_W-1:0] granted_index;
    logic [FREED_W-1:0] freed_blocks;
  } bba_out_t;

endpackage

>>> sv/bba_ram.sv
module bba_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> sv/buddy_block_allocator_unit.sv
// buddy allocator: free bits of all orders live in one word-wide ram
// one item at a time: in_stall is high outside idle; a rejected item goes from check
// straight to done; an alloc counts orders, scans words and splits down, a free visits
// orders upward and merges buddies; each ram step waits on the registered ram read
// reset: synchronous; a clearing pass writes all WORDS (260) ram words before the first item
module buddy_block_allocator_unit import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bba_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bba_out_t out_data
);

`include "buddy_block_allocator_unit_assert.svh"

  fsm_t state_r, state_nxt;

  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [0:0]         act_r, act_nxt;
  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [REQ_W-1:0]   idx_r, idx_nxt;
  logic [ORD_W-1:0]   k_r, k_nxt;
  logic [ORD_W-1:0]   cur_r, cur_nxt;
  logic [WPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [POS_W-1:0]   base_r, base_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [GRANT_W-1:0] granted_r, granted_nxt;
  logic [FREED_W-1:0] freed_r, freed_nxt;
  logic [AW-1:0]      wa_r, wa_nxt;
  logic [CNT_W-1:0]   cnt_r [ORDERS];
  logic               out_valid_r, out_valid_nxt;
  bba_out_t           out_data_r, out_data_nxt;

  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_val;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // decoded helpers
  logic [KREQ_W-1:0] kreq;
  logic              size_bad, idx_bad;
  logic [CNT_W-1:0]  cnt_cur;
  logic [POS_W-1:0]  pos_cur, pos_split;
  logic [WBIT_W-1:0] lb, sb, fb, bud;
  logic [WORD_W-1:0] fword;
  logic              merge;
  logic              out_free;

  assign kreq      = ceil_log2(req_r);
  assign size_bad  = (req_r == '0) || (kreq >= KREQ_W'(ORDERS));
  assign idx_bad   = (idx_r >= REQ_W'(1 << TOP));
  assign cnt_cur   = cnt_r[cur_r];
  assign pos_cur   = base_r >> cur_r;
  assign pos_split = pos_cur | POS_W'(1);
  assign lb        = low_bit(ram_rdata);
  assign sb        = pos_split[WBIT_W-1:0];
  assign fb        = pos_cur[WBIT_W-1:0];
  assign bud       = fb ^ WBIT_W'(1);
  assign fword     = ram_rdata | (WORD_W'(1) << fb);
  assign merge     = (cur_r != ORD_W'(TOP)) && ram_rdata[bud];
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bba_ram #(.DEPTH(WORDS), .WIDTH(WORD_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_addr_r == AW'(WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (size_bad) state_nxt = S_DONE;
        else if (act_r == ACT_ALLOC) state_nxt = S_A_CNT;
        else if (idx_bad) state_nxt = S_DONE;
        else state_nxt = S_F_RD;
      end
      S_A_CNT: begin
        if (cnt_cur != '0) state_nxt = S_A_RD;
        else if (cur_r == ORD_W'(TOP)) state_nxt = S_DONE;
      end
      S_A_RD:  state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (ram_rdata == '0) state_nxt = S_A_RD;
        else if (cur_r == k_r) state_nxt = S_DONE;
        else state_nxt = S_S_RD;
      end
      S_S_RD:  state_nxt = S_S_WR;
      S_S_WR:  state_nxt = (cur_r == k_r) ? S_DONE : S_S_RD;
      S_F_RD:  state_nxt = S_F_WR;
      S_F_WR:  state_nxt = merge ? S_F_RD : S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    act_nxt       = act_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    wptr_nxt      = wptr_r;
    base_nxt      = base_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    freed_nxt     = freed_r;
    wa_nxt        = wa_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cnt_we        = 1'b0;
    cnt_val       = cnt_cur;
    ram_we        = 1'b0;
    ram_waddr     = wa_r;
    ram_wdata     = '0;
    ram_raddr     = obase(cur_r) + AW'(pos_cur[POS_W-1:WBIT_W]);
    case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = (clr_addr_r == obase(ORD_W'(TOP))) ? WORD_W'(1) : '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_data.action;
          req_nxt = in_data.request_blocks;
          idx_nxt = in_data.block_index;
        end
      end
      S_CHECK: begin
        status_nxt  = ST_OK;
        granted_nxt = '0;
        freed_nxt   = '0;
        k_nxt       = kreq[ORD_W-1:0];
        cur_nxt     = kreq[ORD_W-1:0];
        base_nxt    = idx_r[POS_W-1:0] & ~((POS_W'(1) << kreq) - POS_W'(1));
        if (size_bad) status_nxt = ST_SIZE;
        else if (act_r == ACT_FREE) begin
          if (idx_bad) status_nxt = ST_RANGE;
          else freed_nxt = FREED_W'(1) << kreq;
        end
      end
      S_A_CNT: begin
        wptr_nxt = '0;
        if (cnt_cur == '0) begin
          if (cur_r == ORD_W'(TOP)) status_nxt = ST_NOFREE;
          else cur_nxt = cur_r + ORD_W'(1);
        end
      end
      S_A_RD: begin
        ram_raddr = obase(cur_r) + AW'(wptr_r);
        wa_nxt    = ram_raddr;
      end
      S_A_CHK: begin
        if (ram_rdata == '0) wptr_nxt = wptr_r + WPTR_W'(1);
        else begin
          ram_we      = 1'b1;
          ram_wdata   = ram_rdata & ~(WORD_W'(1) << lb);
          cnt_we      = 1'b1;
          cnt_val     = cnt_cur - CNT_W'(1);
          base_nxt    = POS_W'({wptr_r, lb}) << cur_r;
          granted_nxt = GRANT_W'(POS_W'({wptr_r, lb}) << cur_r);
          if (cur_r != k_r) cur_nxt = cur_r - ORD_W'(1);
        end
      end
      S_S_RD: begin
        ram_raddr = obase(cur_r) + AW'(pos_split[POS_W-1:WBIT_W]);
        wa_nxt    = ram_raddr;
      end
      S_S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | (WORD_W'(1) << sb);
        if (!ram_rdata[sb]) begin
          cnt_we  = 1'b1;
          cnt_val = cnt_cur + CNT_W'(1);
        end
        if (cur_r != k_r) cur_nxt = cur_r - ORD_W'(1);
      end
      S_F_RD: begin
        wa_nxt = ram_raddr;
      end
      S_F_WR: begin
        ram_we  = 1'b1;
        cnt_we  = 1'b1;
        cnt_val = cnt_cur + (ram_rdata[fb] ? CNT_W'(0) : CNT_W'(1));
        if (merge) begin
          // base and buddy both leave this order, the parent becomes free
          ram_wdata = fword & ~((WORD_W'(1) << fb) | (WORD_W'(1) << bud));
          cnt_val   = cnt_val - CNT_W'(2);
          base_nxt  = base_r & ~(POS_W'(1) << cur_r);
          cur_nxt   = cur_r + ORD_W'(1);
        end else begin
          ram_wdata = fword;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.granted_index = granted_r;
          out_data_nxt.freed_blocks  = freed_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ORDERS; i++) begin
        cnt_r[i] <= (i == TOP) ? CNT_W'(1) : '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cnt_we) cnt_r[cur_r] <= cnt_val;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    cur_r      <= cur_nxt;
    wptr_r     <= wptr_nxt;
    base_r     <= base_nxt;
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
    freed_r    <= freed_nxt;
    wa_r       <= wa_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  `BBA_CHECK(a_result_from_done, $rose(out_valid_r) |-> $past(state_r) == S_DONE, "result not from done")
  `BBA_CHECK(a_scan_order, state_r == S_A_CHK |-> cur_r >= k_r, "scan below request order")
  `BBA_CHECK(a_grant_aligned, (state_r == S_DONE && status_r == ST_OK && act_r == ACT_ALLOC) |-> (POS_W'(granted_r) & ((POS_W'(1) << k_r) - POS_W'(1))) == '0, "grant misaligned")
  `BBA_HOLD(a_out_hold, out_valid_r, out_stall, out_data_r, "result changed while stalled")

endmodule
